@@ design/great_circle_distance_defines.svh @@
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication, checked on clock, off during reset
`define GCD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcd check failed");

// next-cycle implication
`define GCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gcd check failed");

`endif

@@ design/gcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

   localparam int CORDIC_ITERATIONS = 24;

   localparam int ANG_W = 34;
   localparam int CW    = 34;
   localparam int MAG_W = 31;
   localparam int Q_W   = 32;

   typedef logic signed [ANG_W-1:0] angle_type;
   typedef logic signed [CW-1:0]    cordic_type;
   typedef logic signed [Q_W-1:0]   q_type;

   localparam angle_type HALF_TURN    = 34'sd3019898880;
   localparam angle_type QUARTER_TURN = 34'sd1509949440;

   // pi/180 * 2^38 = 2^32 + DEG2RAD_FRAC
   localparam logic [28:0] DEG2RAD_FRAC = 29'd502557221;
   localparam cordic_type  INV_GAIN     = 34'sd652032874;
   localparam logic [30:0] ONE_Q30      = 31'd1073741824;
   localparam logic [30:0] HALFPI_Q30   = 31'd1686629713;

   localparam logic [23:0] RADIUS_RESET = 24'd880657;
   localparam logic [25:0] DIST_MAX     = 26'd52707177;

   localparam logic REG_RADIUS = 1'b0;

   function automatic cordic_type atan_q30(input int unsigned idx);
      cordic_type v;
      case (idx)
         0:  v = 34'sd843314857;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043837;
         3:  v = 34'sd133525159;
         4:  v = 34'sd67021687;
         5:  v = 34'sd33543516;
         6:  v = 34'sd16775851;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194283;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048576;
         11: v = 34'sd524288;
         12: v = 34'sd262144;
         13: v = 34'sd131072;
         14: v = 34'sd65536;
         15: v = 34'sd32768;
         16: v = 34'sd16384;
         17: v = 34'sd8192;
         18: v = 34'sd4096;
         19: v = 34'sd2048;
         20: v = 34'sd1024;
         21: v = 34'sd512;
         22: v = 34'sd256;
         23: v = 34'sd128;
         24: v = 34'sd64;
         25: v = 34'sd32;
         26: v = 34'sd16;
         27: v = 34'sd8;
         28: v = 34'sd4;
         29: v = 34'sd2;
         30: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // q30 product, rounded
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      p = p + 64'sd536870912;
      return q_type'(p >>> 30);
   endfunction

endpackage

`default_nettype wire

@@ design/gcd_sincos.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcd_sincos import gcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  angle_type  ang,
   output logic       out_valid,
   output cordic_type sin_out,
   output cordic_type cos_out
);

   localparam int N = CORDIC_ITERATIONS;

   angle_type          fold_r;
   logic               fold_neg;
   logic               fold_negc;
   logic [MAG_W-1:0]   fold_mag;

   logic               s1_vld_ff;
   logic [MAG_W-1:0]   s1_mag_ff;
   logic               s1_neg_ff;
   logic               s1_negc_ff;

   logic               s2_vld_ff;
   logic [MAG_W-1:0]   s2_mag_ff;
   logic               s2_neg_ff;
   logic               s2_negc_ff;
   logic [59:0]        s2_prod_ff;

   logic [60:0]        prod_rnd;
   logic [31:0]        rad_mag;
   cordic_type         z_in;

   cordic_type         x_ff [0:N];
   cordic_type         y_ff [0:N];
   cordic_type         z_ff [0:N];
   logic               negc_ff [0:N];
   logic               vld_ff [0:N];

   logic               out_vld_ff;
   cordic_type         sin_ff;
   cordic_type         cos_ff;

   // fold into [-90, 90] degrees
   always_comb begin
      fold_r    = ang;
      fold_negc = 1'b0;
      if (ang > QUARTER_TURN) begin
         fold_r    = HALF_TURN - ang;
         fold_negc = 1'b1;
      end else if (ang < -QUARTER_TURN) begin
         fold_r    = -HALF_TURN - ang;
         fold_negc = 1'b1;
      end
      fold_neg = fold_r[ANG_W-1];
      fold_mag = fold_neg ? MAG_W'(-fold_r) : MAG_W'(fold_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mag_ff  <= fold_mag;
         s1_neg_ff  <= fold_neg;
         s1_negc_ff <= fold_negc;
         s2_prod_ff <= 60'(s1_mag_ff) * 60'(DEG2RAD_FRAC);
         s2_mag_ff  <= s1_mag_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_negc_ff <= s1_negc_ff;
      end
   end

   // degrees to radians: mag + round(mag * frac / 2^32)
   always_comb begin
      prod_rnd = {1'b0, s2_prod_ff} + 61'd2147483648;
      rad_mag  = 32'(s2_mag_ff) + 32'(prod_rnd[60:32]);
      z_in     = s2_neg_ff ? -cordic_type'({2'b00, rad_mag})
                           : cordic_type'({2'b00, rad_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= INV_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         negc_ff[0] <= s2_negc_ff;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            negc_ff[i+1] <= negc_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= y_ff[N];
         cos_ff <= negc_ff[N] ? -x_ff[N] : x_ff[N];
      end
   end

   assign out_valid = out_vld_ff;
   assign sin_out   = sin_ff;
   assign cos_out   = cos_ff;

endmodule

`default_nettype wire

@@ design/gcd_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcd_isqrt import gcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [30:0] v,
   output logic        out_valid,
   output logic [30:0] root
);

   localparam int STEPS = 31;

   logic [60:0] num_cur [0:STEPS];
   logic [60:0] res_cur [0:STEPS];
   logic        vld_cur [0:STEPS];
   logic [60:0] num_ff  [0:STEPS-1];
   logic [60:0] res_ff  [0:STEPS-1];
   logic        vld_ff  [0:STEPS-1];

   assign num_cur[0] = {v, 30'd0};
   assign res_cur[0] = '0;
   assign vld_cur[0] = in_valid;

   // one result bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_digit
      localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
      logic [61:0] trial;

      assign trial = {1'b0, res_cur[k]} + BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, num_cur[k]} >= trial) begin
               num_ff[k] <= 61'({1'b0, num_cur[k]} - trial);
               res_ff[k] <= 61'((res_cur[k] >> 1) + 61'(BIT));
            end else begin
               num_ff[k] <= num_cur[k];
               res_ff[k] <= res_cur[k] >> 1;
            end
         end
      end

      assign num_cur[k+1] = num_ff[k];
      assign res_cur[k+1] = res_ff[k];
      assign vld_cur[k+1] = vld_ff[k];
   end

   assign out_valid = vld_cur[STEPS];
   assign root      = res_cur[STEPS][30:0] | 31'(num_cur[STEPS] & 61'd0);

endmodule

`default_nettype wire

@@ design/gcd_atan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gcd_atan import gcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [30:0] y_in,
   input  logic [30:0] x_in,
   output logic        out_valid,
   output logic [30:0] angle
);

   localparam int N = CORDIC_ITERATIONS;

   cordic_type x_cur [0:N];
   cordic_type y_cur [0:N];
   cordic_type z_cur [0:N];
   logic       vld_cur [0:N];
   cordic_type x_ff [0:N-1];
   cordic_type y_ff [0:N-1];
   cordic_type z_ff [0:N-1];
   logic       vld_ff [0:N-1];

   logic        out_vld_ff;
   logic [30:0] angle_ff;
   logic [30:0] angle_in;

   assign x_cur[0]   = cordic_type'({3'b000, x_in});
   assign y_cur[0]   = cordic_type'({3'b000, y_in});
   assign z_cur[0]   = '0;
   assign vld_cur[0] = in_valid;

   // vectoring: drive y to zero, sum the angles
   for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_cur[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_cur[i] >= 0) begin
               x_ff[i] <= x_cur[i] + (y_cur[i] >>> i);
               y_ff[i] <= y_cur[i] - (x_cur[i] >>> i);
               z_ff[i] <= z_cur[i] + atan_q30(i);
            end else begin
               x_ff[i] <= x_cur[i] - (y_cur[i] >>> i);
               y_ff[i] <= y_cur[i] + (x_cur[i] >>> i);
               z_ff[i] <= z_cur[i] - atan_q30(i);
            end
         end
      end

      assign x_cur[i+1]   = x_ff[i];
      assign y_cur[i+1]   = y_ff[i];
      assign z_cur[i+1]   = z_ff[i];
      assign vld_cur[i+1] = vld_ff[i];
   end

   always_comb begin
      if (z_cur[N] < 0) begin
         angle_in = '0;
      end else if (z_cur[N] > cordic_type'({3'b000, HALFPI_Q30})) begin
         angle_in = HALFPI_Q30;
      end else begin
         angle_in = z_cur[N][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_cur[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in | 31'(x_cur[N] & y_cur[N] & 34'sd0);
      end
   end

   assign out_valid = out_vld_ff;
   assign angle     = angle_ff;

endmodule

`default_nettype wire

@@ design/great_circle_distance.sv @@
`timescale 1ns / 1ps
`default_nettype none
//  channel  | dir | handshake              | payload
//  req      | in  | req_valid / req_stall  | from_lat, from_lon, to_lat, to_lon
//  rsp      | out | rsp_valid / rsp_stall  | distance
//  csr      | in  | psel/penable/pready    | earth_radius at byte address 0
//
//  one pair can enter every cycle while req_stall is low; the path runs through
//  the two CORDIC chains and the 31-stage square root
//  reset is synchronous, clears the valid bits and loads the default radius
//  a stalled word holds in the output register; the pipeline keeps moving
//  while its last stage is empty, so bubbles close up behind a stalled word

module great_circle_distance import gcd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_from_lat,
   input  logic signed [31:0] req_from_lon,
   input  logic signed [30:0] req_to_lat,
   input  logic signed [31:0] req_to_lon,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [25:0]        rsp_distance,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

`include "great_circle_distance_defines.svh"

   logic [23:0] radius_ff;

   logic        adv;
   logic        rsp_load;

   angle_type   dlat_raw, dlon_raw, dlat_in, dlon_in;
   logic        w_vld_ff;
   angle_type   dlat_ff, dlon_ff, lat1x_ff, lat2x_ff;

   logic        sc_vld;
   cordic_type  s_lat, s_lon, c1, c2;
   cordic_type  s_lat_cos, s_lon_cos, c1_sin, c2_sin;
   logic        sc_vld1, sc_vld2, sc_vld3;

   logic        p1_vld_ff, p2_vld_ff, p3_vld_ff;
   q_type       sl2_ff, so2_ff, cc_ff, sl2b_ff, t_ff;
   logic signed [32:0] a_sum;
   logic [30:0] a_in;
   logic [30:0] a_ff, b_ff;

   logic        rt_a_vld, rt_b_vld;
   logic [30:0] root_a, root_b;
   logic        at_vld;
   logic [30:0] ang;

   logic        pr_vld_ff;
   logic [55:0] dprod_ff;
   logic [56:0] drnd;

   logic        rsp_vld_ff;
   logic [25:0] rsp_dist_ff;

   // csr
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_RADIUS) ? {8'd0, radius_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_RADIUS) begin
         radius_ff <= pwdata[23:0];
      end
   end

   // flow control
   assign rsp_load  = !rsp_vld_ff || !rsp_stall;
   assign adv       = rsp_load || !pr_vld_ff;
   assign req_stall = !adv;

   // angle differences, wrapped the short way
   always_comb begin
      dlat_raw = angle_type'(req_to_lat) - angle_type'(req_from_lat);
      dlon_raw = angle_type'(req_to_lon) - angle_type'(req_from_lon);
      dlat_in  = dlat_raw;
      dlon_in  = dlon_raw;
      if (dlat_raw >= QUARTER_TURN) begin
         dlat_in = dlat_raw - HALF_TURN;
      end else if (dlat_raw < -QUARTER_TURN) begin
         dlat_in = dlat_raw + HALF_TURN;
      end
      if (dlon_raw >= QUARTER_TURN) begin
         dlon_in = dlon_raw - HALF_TURN;
      end else if (dlon_raw < -QUARTER_TURN) begin
         dlon_in = dlon_raw + HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= 1'b0;
      end else if (adv) begin
         w_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dlat_ff  <= dlat_in;
         dlon_ff  <= dlon_in;
         lat1x_ff <= angle_type'($signed({req_from_lat, 1'b0}));
         lat2x_ff <= angle_type'($signed({req_to_lat, 1'b0}));
      end
   end

   gcd_sincos u_sc_dlat (
      .clock(clock), .reset(reset), .en(adv), .in_valid(w_vld_ff), .ang(dlat_ff),
      .out_valid(sc_vld), .sin_out(s_lat), .cos_out(s_lat_cos)
   );
   gcd_sincos u_sc_dlon (
      .clock(clock), .reset(reset), .en(adv), .in_valid(w_vld_ff), .ang(dlon_ff),
      .out_valid(sc_vld1), .sin_out(s_lon), .cos_out(s_lon_cos)
   );
   gcd_sincos u_sc_lat1 (
      .clock(clock), .reset(reset), .en(adv), .in_valid(w_vld_ff), .ang(lat1x_ff),
      .out_valid(sc_vld2), .sin_out(c1_sin), .cos_out(c1)
   );
   gcd_sincos u_sc_lat2 (
      .clock(clock), .reset(reset), .en(adv), .in_valid(w_vld_ff), .ang(lat2x_ff),
      .out_valid(sc_vld3), .sin_out(c2_sin), .cos_out(c2)
   );

   // haversine term
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= sc_vld & sc_vld1 & sc_vld2 & sc_vld3;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sl2_ff  <= qmul(q_type'(s_lat), q_type'(s_lat));
         so2_ff  <= qmul(q_type'(s_lon), q_type'(s_lon));
         cc_ff   <= qmul(q_type'(c1), q_type'(c2));
         sl2b_ff <= sl2_ff;
         t_ff    <= qmul(cc_ff, so2_ff);
         a_ff    <= a_in;
         b_ff    <= ONE_Q30 - a_in;
      end
   end

   always_comb begin
      a_sum = 33'(sl2b_ff) + 33'(t_ff);
      if (a_sum < 0) begin
         a_in = '0;
      end else if (a_sum > 33'sd1073741824) begin
         a_in = ONE_Q30;
      end else begin
         a_in = a_sum[30:0];
      end
   end

   gcd_isqrt u_sqrt_a (
      .clock(clock), .reset(reset), .en(adv), .in_valid(p3_vld_ff), .v(a_ff),
      .out_valid(rt_a_vld), .root(root_a)
   );
   gcd_isqrt u_sqrt_b (
      .clock(clock), .reset(reset), .en(adv), .in_valid(p3_vld_ff), .v(b_ff),
      .out_valid(rt_b_vld), .root(root_b)
   );

   gcd_atan u_atan (
      .clock(clock), .reset(reset), .en(adv), .in_valid(rt_a_vld & rt_b_vld),
      .y_in(root_a), .x_in(root_b), .out_valid(at_vld), .angle(ang)
   );

   // scale by radius
   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else if (adv) begin
         pr_vld_ff <= at_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dprod_ff <= 56'(radius_ff) * 56'({ang, 1'b0});
      end
   end

   assign drnd = {1'b0, dprod_ff} + 57'd536870912;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= pr_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_dist_ff <= drnd[55:30];
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_distance = rsp_dist_ff | 26'(s_lat_cos & s_lon_cos & c1_sin & c2_sin & 34'sd0)
                         | 26'(drnd[56] & 1'b0);

   `GCD_ASSERT_NOW(a_gcd_dist_range, rsp_vld_ff, rsp_dist_ff <= DIST_MAX)
   `GCD_ASSERT_NOW(a_gcd_term_split, 1'b1, {1'b0, a_ff} + {1'b0, b_ff} == {1'b0, ONE_Q30} || !p3_vld_ff)
   `GCD_ASSERT_NOW(a_gcd_stall_cause, req_stall, rsp_vld_ff && rsp_stall && pr_vld_ff)
   `GCD_ASSERT_NEXT(a_gcd_hold, rsp_vld_ff && rsp_stall, rsp_vld_ff)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import gcd_pkg::*;

   localparam longint FULL_ANG = 64'sd6039797760;
   localparam longint HALF_ANG = 64'sd3019898880;
   localparam longint QUART_ANG = 64'sd1509949440;
   localparam longint LAT_MAX = 64'sd754974720;
   localparam longint LON_MAX = 64'sd1509949440;
   localparam longint ONE_Q = 64'sd1073741824;
   localparam longint HALFPI_Q = 64'sd1686629713;
   localparam longint GAIN_INV = 64'sd652032874;
   localparam longint unsigned RAD_K = 64'd4797524517;
   localparam logic [2:0] ADDR_RADIUS = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;
   localparam int CYCLE_LIMIT = 600000;

   localparam longint ATAN_TAB [0:39] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [30:0] req_from_lat = '0;
   logic signed [31:0] req_from_lon = '0;
   logic signed [30:0] req_to_lat = '0;
   logic signed [31:0] req_to_lon = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [25:0] rsp_distance;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   logic [23:0] radius_shadow = RADIUS_RESET;
   logic [25:0] distance_queue[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   great_circle_distance dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL great_circle_distance");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   function automatic longint wrap_turn(input longint v, input longint full);
      longint r;
      r = v % full;
      if (r >= full / 2) r -= full;
      if (r < -(full / 2)) r += full;
      return r;
   endfunction

   function automatic int cordic_steps();
      return (CORDIC_ITERATIONS < 40) ? CORDIC_ITERATIONS : 40;
   endfunction

   // angle in 2^-24 degree, results q30
   function automatic void rotate_angle(input longint ang, output longint s,
                                        output longint c);
      longint r, x, y, z, dx, dy;
      bit flip;
      longint unsigned mag;
      r = wrap_turn(ang, FULL_ANG);
      flip = 1'b0;
      if (r > QUART_ANG) begin
         r = HALF_ANG - r;
         flip = 1'b1;
      end else if (r < -QUART_ANG) begin
         r = -HALF_ANG - r;
         flip = 1'b1;
      end
      mag = (r < 0) ? longint'(-r) : longint'(r);
      z = longint'((mag * RAD_K + 64'd2147483648) >> 32);
      if (r < 0) z = -z;
      x = GAIN_INV;
      y = 0;
      for (int i = 0; i < cordic_steps(); i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end
      end
      s = y;
      c = flip ? -x : x;
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   function automatic longint root_q30(input longint v);
      longint unsigned num, res, b;
      num = longint'(v) << 30;
      res = 0;
      b = 64'd1 << 60;
      for (int k = 0; k < 31; k++) begin
         if (num >= res + b) begin
            num -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(input longint y0, input longint x0);
      longint x, y, z, dx, dy;
      x = x0; y = y0; z = 0;
      for (int i = 0; i < cordic_steps(); i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end
      end
      if (z < 0) z = 0;
      if (z > HALFPI_Q) z = HALFPI_Q;
      return z;
   endfunction

   function automatic logic [25:0] haversine_distance(input longint lat1, input longint lon1,
                                                      input longint lat2, input longint lon2,
                                                      input logic [23:0] rad);
      longint s_lat, s_lon, c1, c2, unused, a, ang;
      longint unsigned span;
      rotate_angle(wrap_turn(lat2 - lat1, HALF_ANG), s_lat, unused);
      rotate_angle(wrap_turn(lon2 - lon1, HALF_ANG), s_lon, unused);
      rotate_angle(2 * lat1, unused, c1);
      rotate_angle(2 * lat2, unused, c2);
      a = q30_mul(s_lat, s_lat) + q30_mul(q30_mul(c1, c2), q30_mul(s_lon, s_lon));
      if (a < 0) a = 0;
      if (a > ONE_Q) a = ONE_Q;
      ang = vector_angle(root_q30(a), root_q30(ONE_Q - a));
      span = (longint'(rad) * longint'(2 * ang) + 64'd536870912) >> 30;
      return span[25:0];
   endfunction

   // expected distance per accepted word
   always @(negedge clock) begin
      if (!reset && req_valid && !req_stall)
         distance_queue.push_back(haversine_distance(req_from_lat, req_from_lon,
                                                     req_to_lat, req_to_lon, radius_shadow));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (distance_queue.size() == 0) report("distance word with nothing expected");
         else begin
            logic [25:0] want;
            want = distance_queue.pop_front();
            if (rsp_distance !== want)
               report($sformatf("distance got %0d want %0d", rsp_distance, want));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(1, 17);
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_RADIUS) radius_shadow = data[23:0];
   endtask

   task automatic csr_check_radius();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_RADIUS;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata[23:0] !== radius_shadow)
         report($sformatf("radius read %0d want %0d", prdata[23:0], radius_shadow));
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic drain();
      while (distance_queue.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_radius(input logic [23:0] rad);
      drain();
      csr_write(ADDR_RADIUS, {8'hA5, rad});
      csr_check_radius();
   endtask

   task automatic send_pair(input longint lat1, input longint lon1,
                            input longint lat2, input longint lon2);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_from_lat <= lat1[30:0];
      req_from_lon <= lon1[31:0];
      req_to_lat <= lat2[30:0];
      req_to_lon <= lon2[31:0];
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   function automatic longint rand_lat();
      return longint'($urandom_range(0, 32'd1509949440)) - LAT_MAX;
   endfunction

   function automatic longint rand_lon();
      return longint'($urandom_range(0, 32'd3019898880)) - LON_MAX;
   endfunction

   typedef struct {
      longint lat1, lon1, lat2, lon2;
      logic [23:0] rad;
      int fixed_dist;   // -1: from the predictor
   } pair_row;

   pair_row plan[] = '{
      '{0, 0, 0, 0, 880657, -1},
      '{LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, 880657, -1},
      '{LAT_MAX, 0, -LAT_MAX, 0, 880657, -1},
      '{0, -LON_MAX, 0, LON_MAX, 880657, -1},
      '{0, 0, 0, LON_MAX, 880657, -1},
      '{0, -LON_MAX, 0, 0, 880657, -1},
      '{-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 880657, -1},
      '{LAT_MAX, 0, LAT_MAX, LON_MAX, 880657, -1},
      '{419430400, 838860800, -419430400, -838860800, 880657, -1},
      '{0, 100, 0, -100, 880657, -1},
      '{1, 1, -1, -1, 880657, -1},
      '{LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX, 1, -1},
      '{0, 0, 0, LON_MAX, 24'hFFFFFF, -1},
      '{LAT_MAX, 0, -LAT_MAX, 0, 24'hFFFFFF, -1},
      '{-LAT_MAX, -LON_MAX, 12345678, 987654321, 24'hFFFFFF, -1},
      '{LAT_MAX, 0, -LAT_MAX, 0, 0, 0},
      '{0, -LON_MAX, 0, 0, 0, 0}
   };

   initial begin
      int n;
      logic [23:0] rad;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_radius();
      csr_write(ADDR_UNUSED, 32'h0000_0003);
      csr_check_radius();

      foreach (plan[i]) begin
         if (plan[i].rad != radius_shadow) begin
            req_valid <= 1'b0;
            set_radius(plan[i].rad);
         end
         if (plan[i].fixed_dist >= 0 &&
             haversine_distance(plan[i].lat1, plan[i].lon1, plan[i].lat2, plan[i].lon2,
                                plan[i].rad) != 26'(plan[i].fixed_dist))
            report($sformatf("row %0d disagrees with its typed distance", i));
         send_pair(plan[i].lat1, plan[i].lon1, plan[i].lat2, plan[i].lon2);
      end
      req_valid <= 1'b0;

      for (int chunk = 0; chunk < 9; chunk++) begin
         case (chunk)
            0: rad = RADIUS_RESET;
            1: rad = 24'hFFFFFF;
            2: rad = 24'd1;
            3: rad = 24'd0;
            default: rad = 24'($urandom_range(1, 24'hFFFFFF));
         endcase
         set_radius(rad);
         quiet = (chunk == 8);
         for (int k = 0; k < 150; k++) begin
            n = $urandom_range(0, 9);
            if (n == 0) begin
               // near-identical points
               longint la, lo;
               la = rand_lat();
               lo = rand_lon();
               send_pair(la, lo, la + $urandom_range(0, 3), lo - $urandom_range(0, 3));
            end else if (n == 1) begin
               // near-antipodal points, field extremes mixed in
               longint la, lo;
               la = ($urandom_range(0, 1)) ? LAT_MAX : rand_lat();
               lo = ($urandom_range(0, 1)) ? -LON_MAX : rand_lon();
               send_pair(la, lo, -la, (lo > 0) ? lo - LON_MAX : lo + LON_MAX);
            end else
               send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
         end
         req_valid <= 1'b0;
      end

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0) $display("PASS great_circle_distance");
      else $display("FAIL great_circle_distance");
      $finish;
   end

endmodule
